// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication property on a clock, disabled while reset is asserted (active low).
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/kss_pkg.sv =====
// Shared types and constants of the k-th smallest select unit.
`timescale 1ns / 1ps
`default_nettype none

package kss_pkg;

    localparam int DATA_W        = 32;
    localparam int RANK_W        = 7;
    localparam int STATUS_W      = 2;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic [STATUS_W-1:0] kss_status_t;

    localparam kss_status_t STATUS_OK       = 2'd0;
    localparam kss_status_t STATUS_RANGE    = 2'd1;
    localparam kss_status_t STATUS_OVERFLOW = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic        store;       // write input value, bump count or flag overflow
        logic        cap_rank;    // latch rank of the closing item
        logic        clear;       // empty the set
        logic        cand_start;  // candidate index to zero
        logic        cand_next;   // advance candidate index
        logic        scan_start;  // scan index and tallies to zero
        logic        scan_step;   // read one element and advance scan index
        logic        load_out;    // load result register
        kss_status_t out_status;  // status for the result register
    } kss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic ovf;        // an item was dropped in this set
        logic rank_bad;   // rank zero or beyond count
        logic scan_last;  // scan index at last stored element
        logic found;      // candidate holds rank k
    } kss_stat_t;

endpackage

`default_nettype wire

// ===== hdl/kss_dpath.sv =====
// Datapath: element memory, set count, candidate scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module kss_dpath #(
    parameter int MAX_ITEMS = kss_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire kss_pkg::kss_cmd_t                cmd,
    output kss_pkg::kss_stat_t                    stat,
    input  wire logic signed [kss_pkg::DATA_W-1:0] s_value,
    input  wire logic [kss_pkg::RANK_W-1:0]       s_rank,
    output logic signed [kss_pkg::DATA_W-1:0]     m_selected,
    output kss_pkg::kss_status_t                  m_status
);
    import kss_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int KW = (CW > RANK_W) ? CW : RANK_W;
    localparam int SW = KW + 1;

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];

    logic [CW-1:0]            count_reg;
    logic                     ovf_reg;
    logic [RANK_W-1:0]        rank_reg;
    logic [IW-1:0]            cand_reg;
    logic [IW-1:0]            scan_reg;
    logic [CW-1:0]            less_reg;
    logic [CW-1:0]            eq_reg;
    logic                     b_valid_reg;
    logic signed [DATA_W-1:0] cand_data_reg;
    logic signed [DATA_W-1:0] scan_data_reg;
    logic signed [DATA_W-1:0] m_selected_reg;
    kss_status_t              m_status_reg;

    logic          is_full;
    logic [SW-1:0] k_ext;
    logic [SW-1:0] upto_sum;

    assign is_full  = (count_reg == CW'(MAX_ITEMS));
    assign k_ext    = SW'(rank_reg);
    assign upto_sum = SW'(less_reg) + SW'(eq_reg);

    // Element memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.store && !is_full) begin
            mem[count_reg[IW-1:0]] <= s_value;
        end
        cand_data_reg <= mem[cand_reg];
        scan_data_reg <= mem[scan_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= cmd.scan_step;
            if (cmd.clear) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.store) begin
                if (is_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_rank) begin
            rank_reg <= s_rank;
        end
        if (cmd.cand_start) begin
            cand_reg <= '0;
        end else if (cmd.cand_next) begin
            cand_reg <= cand_reg + IW'(1);
        end
        if (cmd.scan_start) begin
            scan_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_reg <= scan_reg + IW'(1);
        end
        // tally elements below and equal to the candidate
        if (cmd.scan_start) begin
            less_reg <= '0;
            eq_reg   <= '0;
        end else if (b_valid_reg) begin
            if (scan_data_reg < cand_data_reg) begin
                less_reg <= less_reg + CW'(1);
            end else if (scan_data_reg == cand_data_reg) begin
                eq_reg <= eq_reg + CW'(1);
            end
        end
        if (cmd.load_out) begin
            m_status_reg   <= cmd.out_status;
            m_selected_reg <= (cmd.out_status == STATUS_OK) ? cand_data_reg : '0;
        end
    end

    assign stat.ovf       = ovf_reg;
    assign stat.rank_bad  = (rank_reg == '0) || (KW'(rank_reg) > KW'(count_reg));
    assign stat.scan_last = (CW'(scan_reg) == (count_reg - CW'(1)));
    assign stat.found     = (k_ext > SW'(less_reg)) && (k_ext <= upto_sum);

    assign m_selected = m_selected_reg;
    assign m_status   = m_status_reg;

endmodule

`default_nettype wire

// ===== hdl/kss_ctrl.sv =====
// Controller: input acceptance and the candidate-by-candidate rank search.
`timescale 1ns / 1ps
`default_nettype none

module kss_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output kss_pkg::kss_cmd_t       cmd,
    input  wire kss_pkg::kss_stat_t stat
);
    import kss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CAND_RD,
        ST_SCAN,
        ST_DRAIN,
        ST_CHECK
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store    = 1'b1;
                    cmd.cap_rank = s_last;
                    if (s_last) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (stat.ovf || stat.rank_bad) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = stat.ovf ? STATUS_OVERFLOW : STATUS_RANGE;
                        cmd.clear      = 1'b1;
                        m_valid_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.cand_start = 1'b1;
                    state_next     = ST_CAND_RD;
                end
            end
            ST_CAND_RD: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.found) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = STATUS_OK;
                        cmd.clear      = 1'b1;
                        m_valid_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/kth_smallest_select_unit.sv =====
// Top level of the k-th smallest select unit.
//
// Input channel (s_): one signed value per transfer, added to the current set.
// The transfer with s_last high closes the set; its s_rank gives k (one-based).
// Result channel (m_): one transfer per closed set, m_selected holding the
// k-th smallest value (duplicates counted) and m_status ok, rank out of range
// or overflow. Values beyond MAX_ITEMS are dropped; the set then reports
// overflow with m_selected zero. The set is emptied once the result is loaded.
// Non-closing items are accepted one per cycle while no search is running. A
// closing item with a bad rank or a seen overflow goes straight to its result;
// otherwise candidates are tried in stored order up to the first stored copy of
// the answer. Each candidate is compared against the set through the second read
// port of the element memory, one element per cycle.
// Reset (aresetn low, synchronous) empties the set and drops any pending result.
// A result waiting on m_ready does not block new values; the search for the
// next set holds before loading its result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module kth_smallest_select_unit #(
    parameter int MAX_ITEMS = kss_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [kss_pkg::DATA_W-1:0] s_value,
    input  wire logic [kss_pkg::RANK_W-1:0]        s_rank,
    input  wire logic                              s_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [kss_pkg::DATA_W-1:0]      m_selected,
    output logic [kss_pkg::STATUS_W-1:0]           m_status
);
    import kss_pkg::*;

    kss_cmd_t  dp_cmd;
    kss_stat_t dp_stat;

    // Sequencer: accepts values, walks candidates, loads the result
    kss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

    // Element memory, tallies and result register
    kss_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .s_value    (s_value),
        .s_rank     (s_rank),
        .m_selected (m_selected),
        .m_status   (m_status)
    );

`include "assert_macros.svh"

    // A failed selection never carries a value
    `ASSERT_PROP(a_zero_on_error, aclk, aresetn, (m_valid && (m_status != STATUS_OK)) |-> (m_selected == '0), "selected not zero on error status")
    // Closing a set always leaves the idle state, so input stalls next cycle
    `ASSERT_PROP(a_busy_after_last, aclk, aresetn, (s_valid && s_ready && s_last) |=> !s_ready, "input still ready after closing transfer")
    // A non-closing value never raises a result
    `ASSERT_PROP(a_no_spurious_result, aclk, aresetn, (s_valid && s_ready && !s_last && !m_valid) |=> !m_valid, "result raised by non-closing transfer")
    // Status codes stay within the defined set
    `ASSERT_NEVER(a_status_code, aclk, aresetn, m_valid && (m_status != STATUS_OK) && (m_status != STATUS_RANGE) && (m_status != STATUS_OVERFLOW), "undefined status code")

endmodule

`default_nettype wire
